[rtl/core/rgbhsv_pkg.sv]
// Package for the RGB to HSV converter: widths, divider stage count and shared types.
// Has no dependencies. All files in rtl/core import it.
package rgbhsv_pkg;
   localparam int COMPONENT_BITS = 16;
   localparam int CW = COMPONENT_BITS;
   localparam int NW = CW + 3;        // numerator n < 6d
   localparam int DW = CW + 3;        // divisor 6d
   localparam int PW = NW + CW;       // product n*M
   localparam int NUM_CELLS = PW;     // one quotient bit per cell
   localparam logic [15:0] FULL_SCALE_RESET = 16'd255;

   // Operands and side data carried down the divider chain.
   typedef struct packed {
      logic          vld;
      logic          gray;
      logic [CW-1:0] m;
      logic [CW-1:0] vmax;
      logic [PW-1:0] hrem;   // hue dividend bits not yet consumed
      logic [DW:0]   hpart;  // hue partial remainder
      logic [PW-1:0] hquo;
      logic [DW-1:0] hdiv;
      logic [PW-1:0] srem;
      logic [DW:0]   spart;
      logic [PW-1:0] squo;
      logic [DW-1:0] sdiv;
   } div_word_type;
endpackage

[rtl/core/rgbhsv_front.sv]
// Front end: clamps the components, finds max/min/chroma, forms n and the products.
// Depends on rgbhsv_pkg.
module rgbhsv_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_vld,
   input  logic [rgbhsv_pkg::CW-1:0]    m,
   input  logic [rgbhsv_pkg::CW-1:0]    red,
   input  logic [rgbhsv_pkg::CW-1:0]    green,
   input  logic [rgbhsv_pkg::CW-1:0]    blue,
   output rgbhsv_pkg::div_word_type     word_out
);
   import rgbhsv_pkg::*;

   logic [CW-1:0] r, g, b, vmax, vmin, d;
   logic [NW-1:0] n;
   logic          vld_ff, gray_ff;
   logic [CW-1:0] m_ff, vmax_ff, d_ff;
   logic [NW-1:0] n_ff;
   logic [PW-1:0] hprod_ff, sprod_ff;

   always_comb begin
      r = (red > m) ? m : red;
      g = (green > m) ? m : green;
      b = (blue > m) ? m : blue;
      vmax = r;
      if (g > vmax) vmax = g;
      if (b > vmax) vmax = b;
      vmin = r;
      if (g < vmin) vmin = g;
      if (b < vmin) vmin = b;
      d = vmax - vmin;
      if (r == vmax) begin
         if (g >= b) n = NW'(g) - NW'(b);
         else n = NW'(g) + 3'd6 * NW'(d) - NW'(b);
      end else if (g == vmax) begin
         n = 2'd2 * NW'(d) + NW'(b) - NW'(r);
      end else begin
         n = 3'd4 * NW'(d) + NW'(r) - NW'(g);
      end
   end

   // stage 1: register operands; stage 2: multiply
   logic          vld2_ff, gray2_ff;
   logic [CW-1:0] m2_ff, vmax2_ff;
   logic [DW-1:0] hdiv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
         vld2_ff <= vld_ff;
      end
      if (en) begin
         gray_ff <= (d == '0);
         m_ff <= m;
         vmax_ff <= vmax;
         d_ff <= d;
         n_ff <= n;
         gray2_ff <= gray_ff;
         m2_ff <= m_ff;
         vmax2_ff <= vmax_ff;
         hprod_ff <= PW'(n_ff) * PW'(m_ff);
         sprod_ff <= PW'(d_ff) * PW'(m_ff);
         hdiv_ff <= 3'd6 * DW'(d_ff);
      end
   end

   always_comb begin
      word_out = '0;
      word_out.vld = vld2_ff;
      word_out.gray = gray2_ff;
      word_out.m = m2_ff;
      word_out.vmax = vmax2_ff;
      word_out.hrem = hprod_ff;
      word_out.hdiv = hdiv_ff;
      word_out.srem = sprod_ff;
      word_out.sdiv = DW'(vmax2_ff);
   end
endmodule

[rtl/core/rgbhsv_cell.sv]
// One restoring-division cell: one quotient bit each for hue and saturation.
// Depends on rgbhsv_pkg.
module rgbhsv_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  rgbhsv_pkg::div_word_type word_in,
   output rgbhsv_pkg::div_word_type word_out
);
   import rgbhsv_pkg::*;

   div_word_type word_in_w, word_ff;
   logic [DW:0]  ht, st;

   always_comb begin
      word_in_w = word_in;
      ht = {word_in.hpart[DW-1:0], word_in.hrem[PW-1]};
      st = {word_in.spart[DW-1:0], word_in.srem[PW-1]};
      word_in_w.hrem = {word_in.hrem[PW-2:0], 1'b0};
      word_in_w.srem = {word_in.srem[PW-2:0], 1'b0};
      if (ht >= {1'b0, word_in.hdiv}) begin
         word_in_w.hpart = ht - {1'b0, word_in.hdiv};
         word_in_w.hquo = {word_in.hquo[PW-2:0], 1'b1};
      end else begin
         word_in_w.hpart = ht;
         word_in_w.hquo = {word_in.hquo[PW-2:0], 1'b0};
      end
      if (st >= {1'b0, word_in.sdiv}) begin
         word_in_w.spart = st - {1'b0, word_in.sdiv};
         word_in_w.squo = {word_in.squo[PW-2:0], 1'b1};
      end else begin
         word_in_w.spart = st;
         word_in_w.squo = {word_in.squo[PW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) word_ff.vld <= 1'b0;
      else if (en) word_ff.vld <= word_in_w.vld;
      if (en) begin
         word_ff.gray <= word_in_w.gray;
         word_ff.m <= word_in_w.m;
         word_ff.vmax <= word_in_w.vmax;
         word_ff.hrem <= word_in_w.hrem;
         word_ff.hpart <= word_in_w.hpart;
         word_ff.hquo <= word_in_w.hquo;
         word_ff.hdiv <= word_in_w.hdiv;
         word_ff.srem <= word_in_w.srem;
         word_ff.spart <= word_in_w.spart;
         word_ff.squo <= word_in_w.squo;
         word_ff.sdiv <= word_in_w.sdiv;
      end
   end

   assign word_out = word_ff;
endmodule

[rtl/core/rgb_to_hsv_convert_core.sv]
// RGB to HSV converter, top level. Uses rgbhsv_pkg, rgbhsv_front and rgbhsv_cell.
//
// Takes one pixel word per clock and returns hue, saturation and brightness scaled to
// the full scale in csr_wdata (reset 255). Components above full scale are clamped.
// The pipeline is two front-end stages (clamp/compare, multiply), one cell per quotient
// bit of the two restoring dividers, and the output register. Throughput is one word
// per clock; the whole pipeline advances together and holds only when the output
// register is full and not taken. Gray pixels give hue and saturation 0.
// Write csr only while idle.
module rgb_to_hsv_convert_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // red[15:0], green[31:16], blue[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // hue[15:0], saturation[31:16], brightness[47:32]
);
   import rgbhsv_pkg::*;

   logic [15:0]  full_scale_ff;
   logic         en;
   div_word_type chain [NUM_CELLS+1];
   logic [CW-1:0] hue, sat;
   logic         out_vld_ff;
   logic [47:0]  out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) full_scale_ff <= FULL_SCALE_RESET;
      else if (csr_we) full_scale_ff <= csr_wdata;
   end

   // advance the pipe when the output slot is free or being emptied
   assign en = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   rgbhsv_front u_front (
      .clock(clock), .reset(reset), .en(en),
      .in_vld(req_tvalid),
      .m(full_scale_ff[CW-1:0]),
      .red(req_tdata[CW-1:0]),
      .green(req_tdata[16+CW-1:16]),
      .blue(req_tdata[32+CW-1:32]),
      .word_out(chain[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      rgbhsv_cell u_cell (
         .clock(clock), .reset(reset), .en(en),
         .word_in(chain[i]), .word_out(chain[i+1])
      );
   end

   // quotients never exceed M by construction; cap kept as a guard
   always_comb begin
      div_word_type w;
      w = chain[NUM_CELLS];
      hue = (w.hquo > PW'(w.m)) ? w.m : w.hquo[CW-1:0];
      sat = (w.squo > PW'(w.m)) ? w.m : w.squo[CW-1:0];
      if (w.gray) begin
         hue = '0;
         sat = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (en) out_vld_ff <= chain[NUM_CELLS].vld;
      if (en) out_data_ff <= {16'(chain[NUM_CELLS].vmax), 16'(sat), 16'(hue)};
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = out_data_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result lost under stall");
   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] <= full_scale_ff && rsp_tdata[31:16] <= full_scale_ff)
      else $error("hue or saturation above full scale");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
endmodule

[verif/hsv_checker.sv]
// Checker for rgb_to_hsv_convert_core: watches both streams, predicts HSV per pixel.
// Depends on rgbhsv_pkg for the component width and the reset full scale.
`timescale 1ns / 100ps

module hsv_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   import rgbhsv_pkg::*;

   typedef struct packed {
      logic [15:0] brightness;
      logic [15:0] saturation;
      logic [15:0] hue;
   } hsv_word_type;

   logic [15:0]  scale;
   hsv_word_type hsv_expected[$];

   function automatic hsv_word_type predict_hsv(logic [47:0] pix, logic [15:0] fs);
      logic [CW-1:0] m, r, g, b, vmax, vmin, d;
      longint n, h, s;
      hsv_word_type w;
      m = fs[CW-1:0];
      r = (pix[CW-1:0] > m) ? m : pix[CW-1:0];
      g = (pix[16+:CW] > m) ? m : pix[16+:CW];
      b = (pix[32+:CW] > m) ? m : pix[32+:CW];
      vmax = r;
      if (g > vmax) vmax = g;
      if (b > vmax) vmax = b;
      vmin = r;
      if (g < vmin) vmin = g;
      if (b < vmin) vmin = b;
      d = vmax - vmin;
      h = 0;
      s = 0;
      if (d != 0) begin
         s = (longint'(d) * m) / vmax;
         if (r == vmax) begin
            n = longint'(g) - longint'(b);
            if (n < 0) n += 6 * longint'(d);
         end else if (g == vmax) begin
            n = 2 * longint'(d) + b - r;
         end else begin
            n = 4 * longint'(d) + r - g;
         end
         if (n < 0) n = 0;
         h = (n * m) / (6 * longint'(d));
         if (h > m) h = m;
         if (s > m) s = m;
      end
      w.hue = h[15:0];
      w.saturation = s[15:0];
      w.brightness = 16'(vmax);
      return w;
   endfunction

   always @(posedge clock) begin
      hsv_word_type got, want;
      int errs;
      errs = 0;
      if (reset) begin
         scale <= FULL_SCALE_RESET;
         fail_count <= 0;
         pending <= 0;
         hsv_expected.delete();
      end else begin
         if (csr_we) scale <= csr_wdata;
         if (req_tvalid && req_tready) hsv_expected.push_back(predict_hsv(req_tdata, scale));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (hsv_expected.size() == 0) begin
               $error("unexpected word: %h", rsp_tdata);
               errs = errs + 1;
            end else begin
               want = hsv_expected.pop_front();
               if (got.hue !== want.hue) begin
                  $error("hue: expected %0d, got %0d", want.hue, got.hue);
                  errs = errs + 1;
               end
               if (got.saturation !== want.saturation) begin
                  $error("saturation: expected %0d, got %0d", want.saturation,
                         got.saturation);
                  errs = errs + 1;
               end
               if (got.brightness !== want.brightness) begin
                  $error("brightness: expected %0d, got %0d", want.brightness,
                         got.brightness);
                  errs = errs + 1;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending <= hsv_expected.size();
      end
   end

endmodule

[verif/tb.sv]
// Testbench top for rgb_to_hsv_convert_core: drives pixels, full-scale writes, stalls.
// Depends on rgbhsv_pkg, the core and hsv_checker.
`timescale 1ns / 100ps

module tb;
   import rgbhsv_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   int          fail_count;
   int          pending;
   int          rx_idle_pct = 0;
   logic [15:0] scale_now = FULL_SCALE_RESET;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   rgb_to_hsv_convert_core i_dut (.*);

   hsv_checker i_checker (.*);

   // receiver stall, re-rolled every falling edge
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   // push one pixel word; optionally idles first, returns on the falling edge after
   // the handshake with tvalid still high
   task automatic send_pixel(input logic [15:0] r, g, b, input int tx_idle_pct);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {b, g, r};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // full-scale write; only once the pipeline has drained
   task automatic set_scale(input logic [15:0] fs);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (NUM_CELLS + 8) @(negedge clock);
      csr_wdata <= fs;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      scale_now = fs;
   endtask

   // component biased toward scale edges, sometimes over range
   function automatic logic [15:0] pick_comp(logic [15:0] fs);
      case ($urandom_range(9))
         0: return 16'd0;
         1: return fs;
         2: return 16'($urandom);
         default: return (fs == 0) ? 16'd0 : 16'($urandom_range(fs));
      endcase
   endfunction

   task automatic random_pixels(input int count, input int tx_idle_pct);
      logic [15:0] r, g, b;
      for (int i = 0; i < count; i++) begin
         r = pick_comp(scale_now);
         g = pick_comp(scale_now);
         b = pick_comp(scale_now);
         // ties between channels exercise the sector priority
         if ($urandom_range(7) == 0) g = r;
         if ($urandom_range(7) == 0) b = g;
         send_pixel(r, g, b, tx_idle_pct);
      end
   endtask

   initial begin
      int tx_pct;
      logic [15:0] scales[5];
      scales = '{16'd255, 16'd65535, 16'd1, 16'd0, 16'd1023};
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: gray, primaries, each hue sector, wrap, clamping, bit extremes
      rx_idle_pct = 30;
      send_pixel(0, 0, 0, 0);
      send_pixel(255, 255, 255, 0);
      send_pixel(255, 0, 0, 0);
      send_pixel(0, 255, 0, 0);
      send_pixel(0, 0, 255, 0);
      send_pixel(255, 0, 10, 0);       // red max, g<b wraps
      send_pixel(100, 200, 50, 0);
      send_pixel(50, 100, 200, 0);
      send_pixel(200, 200, 10, 0);     // red/green tie
      send_pixel(10, 200, 200, 0);     // green/blue tie
      send_pixel(16'hFFFF, 16'h8000, 16'h0001, 0);  // above scale, clamped
      send_pixel(16'hAAAA, 16'h5555, 16'h0000, 0);
      set_scale(16'hFFFF);
      send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 0);
      send_pixel(16'h5555, 16'hAAAA, 16'hFFFF, 0);
      send_pixel(16'h0001, 16'h0000, 16'h0000, 0);
      send_pixel(16'hFFFE, 16'hFFFF, 16'h0001, 0);
      set_scale(16'd0);
      send_pixel(16'hFFFF, 16'h1234, 16'h0000, 0);
      set_scale(16'd1);
      send_pixel(1, 0, 0, 0);
      send_pixel(0, 1, 1, 0);

      // random phases across several scales and idling mixes
      for (int p = 0; p < 3; p++) begin
         tx_pct      = (p == 0) ? 19 : (p == 1) ? 84 : 0;
         rx_idle_pct = (p == 0) ? 84 : (p == 1) ? 19 : 0;
         for (int k = 0; k < 5; k++) begin
            set_scale(scales[k]);
            random_pixels(70, tx_pct);
            set_scale(16'($urandom_range(2, 65534)));
            random_pixels(30, tx_pct);
         end
      end

      req_tvalid <= 1'b0;
      rx_idle_pct = 0;
      while (pending != 0) @(negedge clock);
      repeat (NUM_CELLS + 8) @(negedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

[rgb_to_hsv_convert_core.f]
rtl/core/rgbhsv_pkg.sv
rtl/core/rgbhsv_front.sv
rtl/core/rgbhsv_cell.sv
rtl/core/rgb_to_hsv_convert_core.sv
verif/hsv_checker.sv
verif/tb.sv
